>>> design/sqr_pkg.sv
package sqr_pkg;

  // cordic datapath
  localparam int CORDIC_STEPS     = 14;
  localparam int CORDIC_PER_STAGE = 2;
  localparam int CW               = 18;
  localparam logic signed [CW-1:0] CORDIC_GAIN = 18'sd9949;

  // divider datapath
  localparam int DIV_NUM_W          = 32;
  localparam int DIV_DEN_W          = 16;
  localparam int DIV_BITS_PER_STAGE = 2;
  localparam int LANES              = 4;

  // lane numbers of the divider
  localparam int LANE_X = 0;
  localparam int LANE_Y = 1;
  localparam int LANE_W = 2;
  localparam int LANE_H = 3;

  // configuration registers
  localparam int CFG_AW = 5;
  localparam logic [2:0] REG_VLEFT = 3'd0;
  localparam logic [2:0] REG_VTOP  = 3'd1;
  localparam logic [2:0] REG_VWID  = 3'd2;
  localparam logic [2:0] REG_VHGT  = 3'd3;
  localparam logic [2:0] REG_SWID  = 3'd4;
  localparam logic [2:0] REG_SHGT  = 3'd5;

  localparam logic [15:0] VLEFT_RST = 16'hEC00;
  localparam logic [15:0] VTOP_RST  = 16'hF100;
  localparam logic [14:0] VWID_RST  = 15'd10240;
  localparam logic [14:0] VHGT_RST  = 15'd7680;
  localparam logic [14:0] SWID_RST  = 15'd10240;
  localparam logic [14:0] SHGT_RST  = 15'd7680;

  // arctangent of 2^-i in 1/65536 turn
  function automatic logic signed [CW-1:0] atan_step(input int i);
    logic signed [CW-1:0] a;
    case (i)
      0:       a = 18'sd8192;
      1:       a = 18'sd4836;
      2:       a = 18'sd2555;
      3:       a = 18'sd1297;
      4:       a = 18'sd651;
      5:       a = 18'sd326;
      6:       a = 18'sd163;
      7:       a = 18'sd81;
      8:       a = 18'sd41;
      9:       a = 18'sd20;
      10:      a = 18'sd10;
      11:      a = 18'sd5;
      12:      a = 18'sd3;
      13:      a = 18'sd1;
      default: a = '0;
    endcase
    return a;
  endfunction

  typedef struct packed {
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic [14:0]        size_w;
    logic [14:0]        size_h;
    logic [8:0]         anchor_x;
    logic [8:0]         anchor_y;
    logic [15:0]        angle;
    logic signed [15:0] tex_u0;
    logic signed [15:0] tex_v0;
    logic signed [15:0] tex_u1;
    logic signed [15:0] tex_v1;
    logic               virtual_coords;
  } req_t;

  typedef struct packed {
    req_t               req;
    logic signed [15:0] c;
    logic signed [15:0] s;
    logic [LANES-1:0]   neg;
  } div_side_t;

endpackage

>>> design/sprite_quad_rotate_setup.sv
// a request passes the input register, the CORDIC stages, the mapping and
//   numerator registers, the divider stages and the d1, d2, d3 and output
//   registers; the output register hands out the four strip vertices one per
//   cycle while out_tready is high, and takes a new request only as the last is taken
// reset: rst_n synchronous active low; clears all valid bits and loads the
//   configuration registers with their default values
module sprite_quad_rotate_setup #(
  parameter int CORDIC_PER_STAGE = sqr_pkg::CORDIC_PER_STAGE,
  parameter int DIV_BPS          = sqr_pkg::DIV_BITS_PER_STAGE
) (
  input  logic                      clk,
  input  logic                      rst_n,
  // request channel
  input  logic                      in_tvalid,
  output logic                      in_tready,
  // pos_x, pos_y, size_w, size_h, anchor_x, anchor_y, angle,
  // tex_u0, tex_v0, tex_u1, tex_v1
  input  logic [159:0]              in_tdata,
  // virtual_coords
  input  logic                      in_tuser,
  // vertex channel
  output logic                      out_tvalid,
  input  logic                      out_tready,
  // vertex_x, vertex_y, vertex_u, vertex_v, corner_index, zero pad
  output logic [71:0]               out_tdata,
  // last_vertex
  output logic                      out_tlast,
  // configuration port
  input  logic                      cfg_psel,
  input  logic                      cfg_penable,
  input  logic                      cfg_pwrite,
  input  logic [sqr_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [31:0]               cfg_pwdata,
  output logic [31:0]               cfg_prdata,
  output logic                      cfg_pready
);

  localparam int LANES = sqr_pkg::LANES;
  localparam int RW    = 54;  // rotation sum width

  // ---------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------
  logic [15:0] vleft_r, vtop_r;
  logic [14:0] vwid_r, vhgt_r, swid_r, shgt_r;
  logic        cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vleft_r <= sqr_pkg::VLEFT_RST;
      vtop_r  <= sqr_pkg::VTOP_RST;
      vwid_r  <= sqr_pkg::VWID_RST;
      vhgt_r  <= sqr_pkg::VHGT_RST;
      swid_r  <= sqr_pkg::SWID_RST;
      shgt_r  <= sqr_pkg::SHGT_RST;
    end else if (cfg_wr) begin
      case (cfg_paddr[4:2])
        sqr_pkg::REG_VLEFT: vleft_r <= cfg_pwdata[15:0];
        sqr_pkg::REG_VTOP:  vtop_r  <= cfg_pwdata[15:0];
        sqr_pkg::REG_VWID:  vwid_r  <= cfg_pwdata[14:0];
        sqr_pkg::REG_VHGT:  vhgt_r  <= cfg_pwdata[14:0];
        sqr_pkg::REG_SWID:  swid_r  <= cfg_pwdata[14:0];
        sqr_pkg::REG_SHGT:  shgt_r  <= cfg_pwdata[14:0];
        default: ;  // unmapped addresses drop the write
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[4:2])
      sqr_pkg::REG_VLEFT: cfg_prdata = {16'd0, vleft_r};
      sqr_pkg::REG_VTOP:  cfg_prdata = {16'd0, vtop_r};
      sqr_pkg::REG_VWID:  cfg_prdata = {17'd0, vwid_r};
      sqr_pkg::REG_VHGT:  cfg_prdata = {17'd0, vhgt_r};
      sqr_pkg::REG_SWID:  cfg_prdata = {17'd0, swid_r};
      sqr_pkg::REG_SHGT:  cfg_prdata = {17'd0, shgt_r};
      default:            cfg_prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------
  // global pipeline advance: everything moves unless the output register
  // still holds vertices that are not yet taken
  // ---------------------------------------------------------------------
  logic       ob_vld_r;
  logic [1:0] cnt_r;
  logic       en;

  assign en        = !ob_vld_r || (out_tready && cnt_r == 2'd3);
  assign in_tready = en;

  // ---------------------------------------------------------------------
  // input register
  // ---------------------------------------------------------------------
  sqr_pkg::req_t req_in;
  sqr_pkg::req_t s0_req_r;
  logic          s0_vld_r;

  always_comb begin
    req_in.pos_x          = in_tdata[15:0];
    req_in.pos_y          = in_tdata[31:16];
    req_in.size_w         = in_tdata[46:32];
    req_in.size_h         = in_tdata[61:47];
    req_in.anchor_x       = in_tdata[70:62];
    req_in.anchor_y       = in_tdata[79:71];
    req_in.angle          = in_tdata[95:80];
    req_in.tex_u0         = in_tdata[111:96];
    req_in.tex_v0         = in_tdata[127:112];
    req_in.tex_u1         = in_tdata[143:128];
    req_in.tex_v1         = in_tdata[159:144];
    req_in.virtual_coords = in_tuser;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r <= 1'b0;
    end else if (en) begin
      s0_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_req_r <= req_in;
    end
  end

  // ---------------------------------------------------------------------
  // sine and cosine, request rides along as sideband
  // ---------------------------------------------------------------------
  logic               cord_vld;
  logic signed [15:0] cord_c, cord_s;
  sqr_pkg::req_t      cord_req;

  sqr_cordic #(
    .PER_STAGE (CORDIC_PER_STAGE),
    .SIDE_W    ($bits(sqr_pkg::req_t))
  ) u_cordic (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (s0_vld_r),
    .angle     (s0_req_r.angle),
    .in_side   (s0_req_r),
    .out_valid (cord_vld),
    .cos_o     (cord_c),
    .sin_o     (cord_s),
    .out_side  (cord_req)
  );

  // ---------------------------------------------------------------------
  // mapping products: (pos - virtual edge) * screen size, screen size * size
  // ---------------------------------------------------------------------
  logic signed [16:0] dx, dy;
  logic signed [32:0] nx_full, ny_full;
  logic signed [31:0] p0_n_r [LANES];
  logic [14:0]        p0_dx_r, p0_dy_r;
  logic signed [15:0] p0_c_r, p0_s_r;
  sqr_pkg::req_t      p0_req_r;
  logic               p0_vld_r;

  assign dx      = $signed({cord_req.pos_x[15], cord_req.pos_x}) - $signed({vleft_r[15], vleft_r});
  assign dy      = $signed({cord_req.pos_y[15], cord_req.pos_y}) - $signed({vtop_r[15], vtop_r});
  assign nx_full = 33'(dx) * 33'($signed({1'b0, swid_r}));
  assign ny_full = 33'(dy) * 33'($signed({1'b0, shgt_r}));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p0_vld_r <= 1'b0;
    end else if (en) begin
      p0_vld_r <= cord_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p0_n_r[sqr_pkg::LANE_X] <= nx_full[31:0];
      p0_n_r[sqr_pkg::LANE_Y] <= ny_full[31:0];
      p0_n_r[sqr_pkg::LANE_W] <= $signed({2'b0, 30'(swid_r * cord_req.size_w)});
      p0_n_r[sqr_pkg::LANE_H] <= $signed({2'b0, 30'(shgt_r * cord_req.size_h)});
      // a zero virtual size counts as one
      p0_dx_r  <= (vwid_r == 15'd0) ? 15'd1 : vwid_r;
      p0_dy_r  <= (vhgt_r == 15'd0) ? 15'd1 : vhgt_r;
      p0_c_r   <= cord_c;
      p0_s_r   <= cord_s;
      p0_req_r <= cord_req;
    end
  end

  // ---------------------------------------------------------------------
  // rounding numerator 2n + d, folded to unsigned by ones' complement so
  // that floor division reduces to one unsigned divide
  // ---------------------------------------------------------------------
  logic [LANES-1:0][31:0] p1_m_nxt;
  logic [LANES-1:0]       p1_neg_nxt;
  logic [LANES-1:0][31:0] p1_m_r;
  logic [LANES-1:0][15:0] p1_den_r;
  sqr_pkg::div_side_t     p1_side_r;
  logic                   p1_vld_r;

  always_comb begin
    logic signed [33:0] nv;
    for (int l = 0; l < LANES; l++) begin
      if (l == sqr_pkg::LANE_X || l == sqr_pkg::LANE_W) begin
        nv = (34'(p0_n_r[l]) <<< 1) + 34'($signed({1'b0, p0_dx_r}));
      end else begin
        nv = (34'(p0_n_r[l]) <<< 1) + 34'($signed({1'b0, p0_dy_r}));
      end
      p1_neg_nxt[l] = nv[33];
      p1_m_nxt[l]   = nv[33] ? ~nv[31:0] : nv[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_vld_r <= 1'b0;
    end else if (en) begin
      p1_vld_r <= p0_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_m_r                    <= p1_m_nxt;
      p1_den_r[sqr_pkg::LANE_X] <= {p0_dx_r, 1'b0};
      p1_den_r[sqr_pkg::LANE_W] <= {p0_dx_r, 1'b0};
      p1_den_r[sqr_pkg::LANE_Y] <= {p0_dy_r, 1'b0};
      p1_den_r[sqr_pkg::LANE_H] <= {p0_dy_r, 1'b0};
      p1_side_r.req             <= p0_req_r;
      p1_side_r.c               <= p0_c_r;
      p1_side_r.s               <= p0_s_r;
      p1_side_r.neg             <= p1_neg_nxt;
    end
  end

  // ---------------------------------------------------------------------
  // four-lane pipelined divider
  // ---------------------------------------------------------------------
  logic                   div_vld;
  logic [LANES-1:0][31:0] div_q;
  sqr_pkg::div_side_t     div_side;

  sqr_div #(
    .NUM_W  (sqr_pkg::DIV_NUM_W),
    .DEN_W  (sqr_pkg::DIV_DEN_W),
    .BPS    (DIV_BPS),
    .LANES  (LANES),
    .SIDE_W ($bits(sqr_pkg::div_side_t))
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (p1_vld_r),
    .num       (p1_m_r),
    .den       (p1_den_r),
    .in_side   (p1_side_r),
    .out_valid (div_vld),
    .quo       (div_q),
    .out_side  (div_side)
  );

  // ---------------------------------------------------------------------
  // d1: pick mapped or raw position and size
  // ---------------------------------------------------------------------
  logic [LANES-1:0][31:0] qs;
  logic signed [31:0]     d1_x_r, d1_y_r;
  logic [30:0]            d1_w_r, d1_h_r;
  logic signed [15:0]     d1_c_r, d1_s_r;
  logic [8:0]             d1_ax_r, d1_ay_r;
  logic signed [15:0]     d1_u0_r, d1_v0_r, d1_u1_r, d1_v1_r;
  logic                   d1_vld_r;

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      qs[l] = div_side.neg[l] ? ~div_q[l] : div_q[l];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d1_vld_r <= 1'b0;
    end else if (en) begin
      d1_vld_r <= div_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (div_side.req.virtual_coords) begin
        d1_x_r <= qs[sqr_pkg::LANE_X];
        d1_y_r <= qs[sqr_pkg::LANE_Y];
        d1_w_r <= qs[sqr_pkg::LANE_W][30:0];
        d1_h_r <= qs[sqr_pkg::LANE_H][30:0];
      end else begin
        d1_x_r <= 32'(div_side.req.pos_x);
        d1_y_r <= 32'(div_side.req.pos_y);
        d1_w_r <= {16'd0, div_side.req.size_w};
        d1_h_r <= {16'd0, div_side.req.size_h};
      end
      d1_c_r  <= div_side.c;
      d1_s_r  <= div_side.s;
      d1_ax_r <= div_side.req.anchor_x;
      d1_ay_r <= div_side.req.anchor_y;
      d1_u0_r <= div_side.req.tex_u0;
      d1_v0_r <= div_side.req.tex_v0;
      d1_u1_r <= div_side.req.tex_u1;
      d1_v1_r <= div_side.req.tex_v1;
    end
  end

  // ---------------------------------------------------------------------
  // d2: anchor offsets and the four rotation products
  // ---------------------------------------------------------------------
  logic signed [31:0] w_s, h_s;
  logic [40:0]        offx_full, offy_full;
  logic signed [31:0] d2_x_r, d2_y_r;
  logic [30:0]        d2_w_r, d2_h_r;
  logic [32:0]        d2_offx_r, d2_offy_r;
  logic signed [47:0] d2_cw_r, d2_sh_r, d2_sw_r, d2_ch_r;
  logic signed [15:0] d2_u0_r, d2_v0_r, d2_u1_r, d2_v1_r;
  logic               d2_vld_r;

  assign w_s       = $signed({1'b0, d1_w_r});
  assign h_s       = $signed({1'b0, d1_h_r});
  // offset rounds half up
  assign offx_full = 41'(d1_ax_r) * 41'(d1_w_r) + 41'd128;
  assign offy_full = 41'(d1_ay_r) * 41'(d1_h_r) + 41'd128;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d2_vld_r <= 1'b0;
    end else if (en) begin
      d2_vld_r <= d1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d2_x_r    <= d1_x_r;
      d2_y_r    <= d1_y_r;
      d2_w_r    <= d1_w_r;
      d2_h_r    <= d1_h_r;
      d2_offx_r <= offx_full[40:8];
      d2_offy_r <= offy_full[40:8];
      d2_cw_r   <= 48'(d1_c_r) * 48'(w_s);
      d2_sh_r   <= 48'(d1_s_r) * 48'(h_s);
      d2_sw_r   <= 48'(d1_s_r) * 48'(w_s);
      d2_ch_r   <= 48'(d1_c_r) * 48'(h_s);
      d2_u0_r   <= d1_u0_r;
      d2_v0_r   <= d1_v0_r;
      d2_u1_r   <= d1_u1_r;
      d2_v1_r   <= d1_v1_r;
    end
  end

  // ---------------------------------------------------------------------
  // d3: doubled quad centre
  // ---------------------------------------------------------------------
  logic signed [34:0] x0, y0;
  logic signed [36:0] d3_cx2_r, d3_cy2_r;
  logic signed [47:0] d3_cw_r, d3_sh_r, d3_sw_r, d3_ch_r;
  logic signed [15:0] d3_u0_r, d3_v0_r, d3_u1_r, d3_v1_r;
  logic               d3_vld_r;

  assign x0 = 35'(d2_x_r) - $signed({2'b0, d2_offx_r});
  assign y0 = 35'(d2_y_r) - $signed({2'b0, d2_offy_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d3_vld_r <= 1'b0;
    end else if (en) begin
      d3_vld_r <= d2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d3_cx2_r <= (37'(x0) <<< 1) + 37'($signed({1'b0, d2_w_r}));
      d3_cy2_r <= (37'(y0) <<< 1) + 37'($signed({1'b0, d2_h_r}));
      d3_cw_r  <= d2_cw_r;
      d3_sh_r  <= d2_sh_r;
      d3_sw_r  <= d2_sw_r;
      d3_ch_r  <= d2_ch_r;
      d3_u0_r  <= d2_u0_r;
      d3_v0_r  <= d2_v0_r;
      d3_u1_r  <= d2_u1_r;
      d3_v1_r  <= d2_v1_r;
    end
  end

  // ---------------------------------------------------------------------
  // rotated corners, floor by 2^15 and saturate, into the output register
  // strip order: (x0,y1) (x0,y0) (x1,y1) (x1,y0)
  // ---------------------------------------------------------------------
  function automatic logic signed [15:0] sat16(input logic signed [RW-1:0] v);
    logic signed [RW-16:0] sv;
    logic signed [15:0]    r;
    sv = v[RW-1:15];
    if (sv > (RW-15)'(32767)) r = 16'sh7FFF;
    else if (sv < -(RW-15)'(32768)) r = 16'sh8000;
    else r = sv[15:0];
    return r;
  endfunction

  logic signed [RW-1:0] bx, by;
  logic signed [RW-1:0] cw_e, sh_e, sw_e, ch_e;
  logic signed [15:0]   vx_nxt [4];
  logic signed [15:0]   vy_nxt [4];

  assign bx   = (RW'(d3_cx2_r) <<< 14) + RW'(16384);
  assign by   = (RW'(d3_cy2_r) <<< 14) + RW'(16384);
  assign cw_e = RW'(d3_cw_r);
  assign sh_e = RW'(d3_sh_r);
  assign sw_e = RW'(d3_sw_r);
  assign ch_e = RW'(d3_ch_r);

  always_comb begin
    vx_nxt[0] = sat16(bx - cw_e - sh_e);
    vy_nxt[0] = sat16(by - sw_e + ch_e);
    vx_nxt[1] = sat16(bx - cw_e + sh_e);
    vy_nxt[1] = sat16(by - sw_e - ch_e);
    vx_nxt[2] = sat16(bx + cw_e - sh_e);
    vy_nxt[2] = sat16(by + sw_e + ch_e);
    vx_nxt[3] = sat16(bx + cw_e + sh_e);
    vy_nxt[3] = sat16(by + sw_e - ch_e);
  end

  logic signed [15:0] ob_x_r [4];
  logic signed [15:0] ob_y_r [4];
  logic signed [15:0] ob_u0_r, ob_v0_r, ob_u1_r, ob_v1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ob_vld_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else if (en) begin
      ob_vld_r <= d3_vld_r;
      cnt_r    <= 2'd0;
    end else if (out_tready) begin
      cnt_r <= cnt_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ob_x_r  <= vx_nxt;
      ob_y_r  <= vy_nxt;
      ob_u0_r <= d3_u0_r;
      ob_v0_r <= d3_v0_r;
      ob_u1_r <= d3_u1_r;
      ob_v1_r <= d3_v1_r;
    end
  end

  // left corners take u0, bottom corners take v1
  logic signed [15:0] out_u, out_v;

  assign out_u      = cnt_r[1] ? ob_u1_r : ob_u0_r;
  assign out_v      = cnt_r[0] ? ob_v0_r : ob_v1_r;
  assign out_tvalid = ob_vld_r;
  assign out_tlast  = (cnt_r == 2'd3);
  assign out_tdata  = {6'd0, cnt_r, out_v, out_u, ob_y_r[cnt_r], ob_x_r[cnt_r]};

  // ---------------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------------
  a_stall_blocks_input : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |-> !in_tready)
    else $error("request taken while a vertex is stalled");

  a_empty_takes_input : assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("pipeline stalled with empty output register");

  a_corner_steps : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !out_tlast |=>
      out_tvalid && out_tdata[65:64] == $past(out_tdata[65:64]) + 2'd1)
    else $error("vertex sequence broken");

endmodule

>>> design/sqr_cordic.sv
module sqr_cordic #(
  parameter int PER_STAGE = sqr_pkg::CORDIC_PER_STAGE,
  parameter int SIDE_W    = 1
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                in_valid,
  input  logic [15:0]         angle,
  input  logic [SIDE_W-1:0]   in_side,
  output logic                out_valid,
  output logic signed [15:0]  cos_o,
  output logic signed [15:0]  sin_o,
  output logic [SIDE_W-1:0]   out_side
);

  localparam int STAGES = sqr_pkg::CORDIC_STEPS / PER_STAGE;
  localparam int CW     = sqr_pkg::CW;

  logic signed [CW-1:0] x_r [STAGES];
  logic signed [CW-1:0] y_r [STAGES];
  logic signed [CW-1:0] z_r [STAGES];
  logic [1:0]           quad_r [STAGES];
  logic                 zero_r [STAGES];
  logic [SIDE_W-1:0]    side_r [STAGES];
  logic                 vld_r  [STAGES];

  function automatic logic signed [15:0] clamp_q14(input logic signed [CW-1:0] v);
    logic signed [15:0] r;
    if (v > 18'sd16384) r = 16'sd16384;
    else if (v < -18'sd16384) r = -16'sd16384;
    else r = v[15:0];
    return r;
  endfunction

  genvar k;
  for (k = 0; k < STAGES; k++) begin : g_stage
    logic signed [CW-1:0] x_in, y_in, z_in;
    logic signed [CW-1:0] x_nxt, y_nxt, z_nxt;
    logic [1:0]           quad_in;
    logic                 zero_in;
    logic [SIDE_W-1:0]    side_in;
    logic                 vld_in;

    if (k == 0) begin : g_first
      assign x_in    = sqr_pkg::CORDIC_GAIN;
      assign y_in    = '0;
      assign z_in    = CW'({1'b0, angle[13:0]});
      assign quad_in = angle[15:14];
      assign zero_in = (angle[13:0] == 14'd0);
      assign side_in = in_side;
      assign vld_in  = in_valid;
    end else begin : g_next
      assign x_in    = x_r[k-1];
      assign y_in    = y_r[k-1];
      assign z_in    = z_r[k-1];
      assign quad_in = quad_r[k-1];
      assign zero_in = zero_r[k-1];
      assign side_in = side_r[k-1];
      assign vld_in  = vld_r[k-1];
    end

    always_comb begin
      logic signed [CW-1:0] xv, yv, zv, xs, ys;
      xv = x_in;
      yv = y_in;
      zv = z_in;
      for (int j = 0; j < PER_STAGE; j++) begin
        xs = yv >>> (k * PER_STAGE + j);
        ys = xv >>> (k * PER_STAGE + j);
        if (zv >= 0) begin
          xv = xv - xs;
          yv = yv + ys;
          zv = zv - sqr_pkg::atan_step(k * PER_STAGE + j);
        end else begin
          xv = xv + xs;
          yv = yv - ys;
          zv = zv + sqr_pkg::atan_step(k * PER_STAGE + j);
        end
      end
      x_nxt = xv;
      y_nxt = yv;
      z_nxt = zv;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        x_r[k]    <= x_nxt;
        y_r[k]    <= y_nxt;
        z_r[k]    <= z_nxt;
        quad_r[k] <= quad_in;
        zero_r[k] <= zero_in;
        side_r[k] <= side_in;
      end
    end
  end

  logic signed [15:0] c0, s0;

  always_comb begin
    if (zero_r[STAGES-1]) begin
      c0 = 16'sd16384;
      s0 = '0;
    end else begin
      c0 = clamp_q14(x_r[STAGES-1]);
      s0 = clamp_q14(y_r[STAGES-1]);
    end
    case (quad_r[STAGES-1])
      2'd0: begin cos_o = c0;  sin_o = s0;  end
      2'd1: begin cos_o = -s0; sin_o = c0;  end
      2'd2: begin cos_o = -c0; sin_o = -s0; end
      default: begin cos_o = s0; sin_o = -c0; end
    endcase
  end

  assign out_valid = vld_r[STAGES-1];
  assign out_side  = side_r[STAGES-1];

endmodule

>>> design/sqr_div.sv
module sqr_div #(
  parameter int NUM_W  = sqr_pkg::DIV_NUM_W,
  parameter int DEN_W  = sqr_pkg::DIV_DEN_W,
  parameter int BPS    = sqr_pkg::DIV_BITS_PER_STAGE,
  parameter int LANES  = sqr_pkg::LANES,
  parameter int SIDE_W = 1
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             en,
  input  logic                             in_valid,
  input  logic [LANES-1:0][NUM_W-1:0]      num,
  input  logic [LANES-1:0][DEN_W-1:0]      den,
  input  logic [SIDE_W-1:0]                in_side,
  output logic                             out_valid,
  output logic [LANES-1:0][NUM_W-1:0]      quo,
  output logic [SIDE_W-1:0]                out_side
);

  localparam int STG = NUM_W / BPS;

  // numerator and quotient share one shifting word; the partial remainder is kept apart
  logic [LANES-1:0][DEN_W-1:0] rem_r [STG];
  logic [LANES-1:0][NUM_W-1:0] nq_r  [STG];
  logic [LANES-1:0][DEN_W-1:0] den_r [STG];
  logic [SIDE_W-1:0]           side_r [STG];
  logic                        vld_r  [STG];

  genvar k;
  for (k = 0; k < STG; k++) begin : g_stage
    logic [LANES-1:0][DEN_W-1:0] rem_in, rem_nxt, den_in;
    logic [LANES-1:0][NUM_W-1:0] nq_in, nq_nxt;
    logic [SIDE_W-1:0]           side_in;
    logic                        vld_in;

    if (k == 0) begin : g_first
      assign rem_in  = '0;
      assign nq_in   = num;
      assign den_in  = den;
      assign side_in = in_side;
      assign vld_in  = in_valid;
    end else begin : g_next
      assign rem_in  = rem_r[k-1];
      assign nq_in   = nq_r[k-1];
      assign den_in  = den_r[k-1];
      assign side_in = side_r[k-1];
      assign vld_in  = vld_r[k-1];
    end

    always_comb begin
      logic [DEN_W:0]   tv;
      logic [DEN_W-1:0] rv;
      logic [NUM_W-1:0] qv;
      for (int l = 0; l < LANES; l++) begin
        rv = rem_in[l];
        qv = nq_in[l];
        for (int j = 0; j < BPS; j++) begin
          tv = {rv, qv[NUM_W-1]};
          if (tv >= {1'b0, den_in[l]}) begin
            tv = tv - {1'b0, den_in[l]};
            qv = {qv[NUM_W-2:0], 1'b1};
          end else begin
            qv = {qv[NUM_W-2:0], 1'b0};
          end
          rv = tv[DEN_W-1:0];
        end
        rem_nxt[l] = rv;
        nq_nxt[l]  = qv;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= rem_nxt;
        nq_r[k]   <= nq_nxt;
        den_r[k]  <= den_in;
        side_r[k] <= side_in;
      end
    end
  end

  assign out_valid = vld_r[STG-1];
  assign quo       = nq_r[STG-1];
  assign out_side  = side_r[STG-1];

endmodule
